// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the quantizer block.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PQTD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pqtd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PQTD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pqtd assertion failed");

`endif

// ===== design/pqtd_pkg.sv =====
// Package of the TPDF dithered PCM quantizer: widths, register indexes, types
// and the xorshift32 step. Used by pqtd_quant and the top level.
package pqtd_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = 24;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int NUM_W      = PROD_W + 16;
  localparam int WORD_W     = NUM_W - 32;
  localparam int DITHER_W   = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [31:0] DITHER_SEED = 32'h9E37_79B9;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd2;

  // Target word width; the unused code behaves as 32 bits.
  typedef enum logic [1:0] {
    WS_16 = 2'd0,
    WS_24 = 2'd1,
    WS_32 = 2'd2
  } word_size_e;

  // One sample held between the input register and the result register.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
    logic signed [DITHER_W-1:0] dither;
  } item_t;

  // Settings seen by the quantizer datapath.
  typedef struct packed {
    word_size_e               word_size;
    logic signed [GAIN_W-1:0] gain;
  } quant_cfg_t;

  // One step of the xorshift32 generator.
  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

// ===== design/pqtd_quant.sv =====
// Quantizer datapath: gain multiply, dither add, rounding, saturation and
// left justification. Depends on pqtd_pkg.
module pqtd_quant import pqtd_pkg::*; (
  input  item_t       item_i,
  input  quant_cfg_t  cfg_i,
  output logic [31:0] pcm_word_o
);

  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  prod_ext;
  logic signed [NUM_W-1:0]  scaled;
  logic signed [NUM_W-1:0]  num;
  logic signed [NUM_W-1:0]  rounded;
  logic                     neg;
  logic signed [WORD_W-1:0] word;
  logic signed [WORD_W-1:0] hi_lim;
  logic signed [WORD_W-1:0] lo_lim;
  logic signed [WORD_W-1:0] sat;

  // Exact product with 47 fraction bits.
  assign prod     = item_i.sample * cfg_i.gain;
  assign prod_ext = NUM_W'(prod);

  // Scale so that the word LSB sits at bit 32 for every width.
  always_comb begin
    case (cfg_i.word_size)
      WS_16:   scaled = prod_ext;
      WS_24:   scaled = prod_ext <<< 8;
      default: scaled = prod_ext <<< 16;
    endcase
  end

  assign num = scaled + NUM_W'(item_i.dither);
  assign neg = num[NUM_W-1];

  // Round half away from zero: add half an LSB, less one for negative values,
  // then floor by the arithmetic shift.
  assign rounded = num + NUM_W'(32'h7FFF_FFFF) + NUM_W'(!neg);
  assign word    = rounded[NUM_W-1:32];

  // Saturation limits of the selected width.
  always_comb begin
    case (cfg_i.word_size)
      WS_16: begin
        hi_lim = WORD_W'(32'sh0000_7FFF);
        lo_lim = WORD_W'(-32'sh0000_8000);
      end
      WS_24: begin
        hi_lim = WORD_W'(32'sh007F_FFFF);
        lo_lim = WORD_W'(-32'sh0080_0000);
      end
      default: begin
        hi_lim = WORD_W'(32'sh7FFF_FFFF);
        lo_lim = WORD_W'(-33'sh0_8000_0000);
      end
    endcase
  end

  always_comb begin
    if (word > hi_lim) begin
      sat = hi_lim;
    end else if (word < lo_lim) begin
      sat = lo_lim;
    end else begin
      sat = word;
    end
  end

  // Left-justify the word into 32 bits.
  always_comb begin
    case (cfg_i.word_size)
      WS_16:   pcm_word_o = {sat[15:0], 16'h0000};
      WS_24:   pcm_word_o = {sat[23:0], 8'h00};
      default: pcm_word_o = sat[31:0];
    endcase
  end

endmodule

// ===== design/pcm_quantizer_tpdf_dither_top.sv =====
// Top level of the TPDF dithered PCM quantizer: configuration registers,
// dither generator and the two-register word pipeline. Depends on pqtd_pkg
// and pqtd_quant.
//
// Usage:
// - Input channel: in_valid_i with sample_i (signed Q4.27) and block_end_i.
//   A word is taken at a clock edge where in_valid_i is high and in_stall_o
//   is low.
// - Output channel: out_valid_o with pcm_word_o and block_end_out_o. A word
//   leaves at an edge where out_valid_o is high and out_stall_i is low.
// - Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0 word size, 1 dither enable, 2 gain). Write only while the pipe is empty.
// - Path: a word taken in goes to the input register, then to the result
//   register, which drives the output; a stalled output holds it there.
// - Throughput: one word per cycle unless stalled; gain multiply, rounding and
//   saturation sit in one stage between the input and result registers.
// - Dither draws two xorshift32 values per word when enabled at 16 or 24 bits.
// - Reset: the pipe empties, the registers return to 24 bits, no dither, unit
//   gain, and the generator returns to its seed.
// - When the receiver stalls, the result word holds, the input register takes
//   one more word if empty, then in_stall_o rises until the output drains.
module pcm_quantizer_tpdf_dither_top import pqtd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    sample_i,
  input  logic                  block_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    pcm_word_o,
  output logic                  block_end_out_o
);

  word_size_e               word_size_q;
  logic                     dither_en_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic [31:0]              dither_state_q;
  logic [31:0]              dither_state_d;
  logic [31:0]              draw_a;
  logic [31:0]              draw_b;
  logic                     dither_on;
  logic signed [DITHER_W-1:0] dither_val;
  item_t                    item_q;
  logic                     item_valid_q;
  logic                     out_ready;
  logic                     in_accept;
  logic [31:0]              quant_word;
  quant_cfg_t               quant_cfg;
  logic [31:0]              pcm_word_q;
  logic                     block_end_out_q;
  logic                     out_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_size_q <= WS_24;
      dither_en_q <= 1'b0;
      gain_q      <= 24'sh10_0000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WORD_SIZE: word_size_q <= word_size_e'(cfg_data_i[1:0]);
        CFG_DITHER_EN: dither_en_q <= cfg_data_i[0];
        CFG_GAIN:      gain_q      <= signed'(cfg_data_i[GAIN_W-1:0]);
        default:       ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register frees.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = item_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Dither draws: two successive generator steps, taken as a difference.
  assign dither_on  = dither_en_q && (word_size_q == WS_16 || word_size_q == WS_24);
  assign draw_a     = xorshift32(dither_state_q);
  assign draw_b     = xorshift32(draw_a);
  assign dither_val = dither_on ? signed'({1'b0, draw_a}) - signed'({1'b0, draw_b})
                                : '0;

  always_comb begin
    dither_state_d = dither_state_q;
    if (in_accept && dither_on) begin
      dither_state_d = draw_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_state_q <= DITHER_SEED;
    end else begin
      dither_state_q <= dither_state_d;
    end
  end

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        item_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= item_valid_q;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.sample    <= sample_i;
      item_q.block_end <= block_end_i;
      item_q.dither    <= dither_val;
    end
  end

  assign quant_cfg.word_size = word_size_q;
  assign quant_cfg.gain      = gain_q;

  pqtd_quant u_quant (
    .item_i     (item_q),
    .cfg_i      (quant_cfg),
    .pcm_word_o (quant_word)
  );

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (out_ready && item_valid_q) begin
      pcm_word_q      <= quant_word;
      block_end_out_q <= item_q.block_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pcm_word_o      = signed'(pcm_word_q);
  assign block_end_out_o = block_end_out_q;

endmodule

// ===== design/pqtd_checker.sv =====
// Port-level checker of the quantizer top level and its bind statement.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pqtd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pcm_word_o,
  input logic        block_end_out_o
);

  // The input side only stalls while a result waits on a stalled receiver.
  `PQTD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A word taken in reaches the output through the result register when the output is free.
  `PQTD_ASSERT_NXT(a_latency, clk_i, rst_ni, (in_valid_i && !in_stall_o) ##1 !out_stall_i, out_valid_o)

  // A stalled result word stays and holds its value.
  `PQTD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(pcm_word_o) && $stable(block_end_out_o))

endmodule

bind pcm_quantizer_tpdf_dither_top pqtd_checker u_pqtd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .pcm_word_o      (pcm_word_o),
  .block_end_out_o (block_end_out_o)
);

// ===== tb/pqtd_check_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the TPDF dithered PCM quantizer testbench. It predicts each
// output word from the accepted samples and the register settings.
// Depends on pqtd_pkg for register indexes, word size codes and the seed.
package pqtd_check_pkg;
  import pqtd_pkg::*;

  // Register index that selects no register, and the word size code that
  // has no width of its own (it behaves as 32 bits).
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [1:0]           WS_SPARE  = 2'd3;

  typedef struct {
    logic [31:0] pcm;
    logic        block_end;
  } pcm_expect_t;

  class pcm_word_scoreboard;
    logic [1:0]         width_code;
    logic               dither_on;
    logic signed [23:0] gain_q20;
    logic [31:0]        noise_state;
    pcm_expect_t        expected_words[$];
    int unsigned        words_checked;
    int unsigned        words_dithered;
    int unsigned        words_clipped;
    int unsigned        mismatches;

    // Settings and generator state as they come out of reset.
    function new();
      width_code     = WS_24;
      dither_on      = 1'b0;
      gain_q20       = 24'sh10_0000;
      noise_state    = DITHER_SEED;
      words_checked  = 0;
      words_dithered = 0;
      words_clipped  = 0;
      mismatches     = 0;
    endfunction

    // Mirror a register write; only the bits the register holds are kept.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WORD_SIZE: width_code = data[1:0];
        CFG_DITHER_EN: dither_on = data[0];
        CFG_GAIN:      gain_q20 = data;
        default: ;
      endcase
    endfunction

    // Advance the xorshift generator by one draw.
    function logic [31:0] next_draw();
      logic [31:0] s;
      s = noise_state;
      s = s ^ (s << 13);
      s = s ^ (s >> 17);
      s = s ^ (s << 5);
      noise_state = s;
      return s;
    endfunction

    // Work out the word that an accepted sample must produce.
    function void note_sample(logic signed [31:0] smp, logic be);
      int unsigned nbits;
      int unsigned shamt;
      longint      prod;
      longint      num;
      logic [31:0] ra;
      logic [31:0] rb;
      bit [63:0]   mag;
      bit [63:0]   q;
      bit [63:0]   lim;
      bit [63:0]   w;
      bit          neg;
      pcm_expect_t e;
      case (width_code)
        WS_16:   nbits = 16;
        WS_24:   nbits = 24;
        default: nbits = 32;
      endcase
      prod = longint'(smp) * longint'(gain_q20);
      // With dither the sum is kept at 32 fraction bits of the target word.
      if (dither_on && nbits < 32) begin
        ra = next_draw();
        rb = next_draw();
        num = prod * (longint'(1) << (nbits - 16))
              + (longint'({32'd0, ra}) - longint'({32'd0, rb}));
        shamt = 32;
        words_dithered++;
      end else begin
        num = prod;
        shamt = 48 - nbits;
      end
      // Round the magnitude half up so that ties move away from zero.
      neg = num < 0;
      mag = neg ? -num : num;
      q = (mag + (64'd1 << (shamt - 1))) >> shamt;
      lim = 64'd1 << (nbits - 1);
      if (neg && q > lim) begin
        q = lim;
        words_clipped++;
      end else if (!neg && q > lim - 1) begin
        q = lim - 1;
        words_clipped++;
      end
      w = neg ? -q : q;
      w = w << (32 - nbits);
      e.pcm = w[31:0];
      e.block_end = be;
      expected_words = {expected_words, e};
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // Compare a word taken from the output with the oldest prediction.
    function void check_word(logic [31:0] pcm, logic be);
      pcm_expect_t e;
      if (expected_words.size() == 0) begin
        report($sformatf("word %h arrived with none expected", pcm));
        return;
      end
      e = expected_words.pop_front();
      words_checked++;
      if (pcm !== e.pcm)
        report($sformatf("pcm_word of word %0d: expected %h, got %h",
                         words_checked, e.pcm, pcm));
      if (be !== e.block_end)
        report($sformatf("block_end_out of word %0d: expected %b, got %b",
                         words_checked, e.block_end, be));
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench of pcm_quantizer_tpdf_dither_top: corner samples at the reset
// settings, then random samples over many register settings, with stalls.
// Depends on pqtd_pkg and pqtd_check_pkg.
module tb;
  import pqtd_pkg::*;
  import pqtd_check_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_CYCLES     = 64;
  localparam int unsigned ITEMS_PER_PHASE = 115;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [31:0]    sample_i;
  logic                  block_end_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [31:0]    pcm_word_o;
  logic                  block_end_out_o;

  bit          calm;
  bit          hold_req;
  int unsigned phases_run;

  pcm_word_scoreboard words = new();

  pcm_quantizer_tpdf_dither_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .block_end_i    (block_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pcm_word_o     (pcm_word_o),
    .block_end_out_o(block_end_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, none while calm, and a long hold on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 6);
      end
    end
  end

  // Every word that leaves the block is checked against the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) words.check_word(pcm_word_o, block_end_out_o);
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: %0d cycles without a word moving", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one word, with a random gap first, and hold it until taken.
  task automatic send_word(input logic signed [31:0] smp, input logic be);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= smp;
    block_end_i <= be;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words.note_sample(smp, be);
  endtask

  // Stop offering and wait until every predicted word has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (words.outstanding() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    words.write_reg(idx, data);
  endtask

  // Write all three registers; with junk set, unused data bits are random
  // and the spare index is written as well.
  task automatic configure(input logic [1:0] ws, input logic de,
                           input logic [CFG_DATA_W-1:0] g, input bit junk);
    logic [CFG_DATA_W-1:0] d;
    if (junk) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    d = junk ? CFG_DATA_W'($urandom) : '0;
    d[1:0] = ws;
    write_reg(CFG_WORD_SIZE, d);
    d = junk ? CFG_DATA_W'($urandom) : '0;
    d[0] = de;
    write_reg(CFG_DITHER_EN, d);
    write_reg(CFG_GAIN, g);
    cfg_we_i <= 1'b0;
  endtask

  // Random sample: full range, within full scale, near rounding ties, or
  // close to the extremes.
  function automatic logic signed [31:0] pick_sample();
    logic signed [31:0] s;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      s = $urandom;
    end else if (pick < 65) begin
      s = $signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
    end else if (pick < 90) begin
      s = $urandom_range(255) << $urandom_range(28);
      s = s + $signed($urandom_range(2)) - 1;
      if ($urandom_range(1) == 1) s = -s;
    end else begin
      s = ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF - $urandom_range(15)
                                   : 32'sh8000_0000 + $urandom_range(15);
    end
    return s;
  endfunction

  // One setting of the registers followed by a stream of random words.
  task automatic run_phase(input logic [1:0] ws, input logic de,
                           input logic [CFG_DATA_W-1:0] g,
                           input bit hold_out, input bit pause_in);
    configure(ws, de, g, $urandom_range(1) == 1);
    for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (i == 40 && hold_out) hold_req = 1'b1;
      if (i == 60 && pause_in) wait_drained();
      send_word(pick_sample(), $urandom_range(7) == 0);
    end
    wait_drained();
    phases_run++;
  endtask

  // Corner samples at the reset settings: 24 bits, no dither, unit gain.
  logic signed [31:0] corner[16] = '{
    32'sh0000_0000, 32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0007,
    32'sh0000_0008, -32'sh0000_0008, 32'sh0000_0018, -32'sh0000_0018,
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0800_0000, -32'sh0800_0000,
    32'sh07FF_FFF0, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shFFFF_FFF8
  };

  initial begin
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_WORD_SIZE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    block_end_i <= 1'b0;
    rst_ni      <= 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    phases_run  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner[i]) send_word(corner[i], i % 2 == 1);
    wait_drained();

    run_phase(WS_16, 1'b0, 24'h10_0000, 1'b0, 1'b0);
    run_phase(WS_16, 1'b1, 24'h10_0000, 1'b0, 1'b0);
    run_phase(WS_24, 1'b1, 24'h08_0000, 1'b0, 1'b0);
    // No idling on either side for a whole phase.
    calm = 1'b1;
    run_phase(WS_32, 1'b0, 24'h10_0000, 1'b0, 1'b0);
    calm = 1'b0;
    run_phase(WS_32, 1'b1, 24'hF0_0000, 1'b0, 1'b0);
    run_phase(WS_SPARE, 1'b1, 24'h7F_FFFF, 1'b1, 1'b0);
    run_phase(WS_SPARE, 1'b0, 24'h80_0000, 1'b0, 1'b0);
    run_phase(WS_16, 1'b1, 24'h00_0000, 1'b0, 1'b0);
    run_phase(WS_24, 1'b0, CFG_DATA_W'($urandom_range(24'hFF_FFFF)), 1'b0, 1'b1);
    run_phase(WS_24, 1'b1, CFG_DATA_W'($urandom_range(24'hFF_FFFF)), 1'b1, 1'b0);
    run_phase(WS_16, 1'b0, 24'h80_0000, 1'b0, 1'b0);
    run_phase(WS_16, 1'b1, 24'h7F_FFFF, 1'b0, 1'b0);
    run_phase(WS_24, 1'b1, 24'h10_0000, 1'b0, 1'b0);

    repeat (10) @(posedge clk_i);
    $display("Checked %0d words: corner samples at reset plus %0d register settings.",
             words.words_checked, phases_run);
    $display("Of these %0d were dithered and %0d clipped; %0d mismatches.",
             words.words_dithered, words.words_clipped, words.mismatches);
    if (words.mismatches == 0 && words.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
